// ----- hw/rtl/mrkd_pkg.sv -----
`default_nettype none
package mrkd_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_TAB_SIZE     = 24;
	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	// register indexes
	localparam logic [1:0] REG_CASTER_EN = 2'd0;
	localparam logic [1:0] REG_TRACK     = 2'd1;
	localparam logic [1:0] REG_BASE      = 2'd2;
	localparam logic [1:0] REG_INV_LEN   = 2'd3;

	// arctangent table, 2^32 per full turn
	function automatic logic signed [33:0] atan_entry(input int idx);
		logic signed [33:0] r;
		begin
			unique case (idx)
				0: r = 34'sh20000000;
				1: r = 34'sh12E4051E;
				2: r = 34'sh09FB385B;
				3: r = 34'sh051111D4;
				4: r = 34'sh028B0D43;
				5: r = 34'sh0145D7E1;
				6: r = 34'sh00A2F61E;
				7: r = 34'sh00517C55;
				8: r = 34'sh0028BE53;
				9: r = 34'sh00145F2F;
				10: r = 34'sh000A2F98;
				11: r = 34'sh000517CC;
				12: r = 34'sh00028BE6;
				13: r = 34'sh000145F3;
				14: r = 34'sh0000A2FA;
				15: r = 34'sh0000517D;
				16: r = 34'sh000028BE;
				17: r = 34'sh0000145F;
				18: r = 34'sh00000A30;
				19: r = 34'sh00000518;
				20: r = 34'sh0000028C;
				21: r = 34'sh00000146;
				22: r = 34'sh000000A3;
				23: r = 34'sh00000051;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

	// saturate to int32
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		begin
			if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
			else if (v < -64'sd2147483648) return 32'sh80000000;
			else return v[31:0];
		end
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/mrkd_cordic.sv -----
`default_nettype none
// Pipelined CORDIC rotator: one register per stage, stall-aware
module mrkd_cordic
	import mrkd_pkg::*;
#(
	parameter int STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire logic signed [15:0]  ang,
	output logic signed [33:0]       sin_q30,
	output logic signed [33:0]       cos_q30
);
	localparam int NUSED = (STAGES < ATAN_TAB_SIZE) ? STAGES : ATAN_TAB_SIZE;

	logic signed [33:0] x_q [NUSED+1];
	logic signed [33:0] y_q [NUSED+1];
	logic signed [33:0] z_q [NUSED+1];
	logic               flip_q [NUSED+1];

	// fold into +-90 degrees
	logic signed [33:0] z0;
	logic               f0;
	always_comb begin
		z0 = {{2{ang[15]}}, ang, 16'd0};
		f0 = 1'b0;
		if (z0 > 34'sh40000000) begin
			z0 = z0 - 34'sh80000000;
			f0 = 1'b1;
		end else if (z0 < -34'sh40000000) begin
			z0 = z0 + 34'sh80000000;
			f0 = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0] <= CORDIC_GAIN_Q30;
			y_q[0] <= '0;
			z_q[0] <= z0;
			flip_q[0] <= f0;
		end
	end

	for (genvar i = 0; i < NUSED; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				flip_q[i+1] <= flip_q[i];
				if (!z_q[i][33]) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - atan_entry(i);
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + atan_entry(i);
				end
			end
		end
	end

	assign cos_q30 = flip_q[NUSED] ? -x_q[NUSED] : x_q[NUSED];
	assign sin_q30 = flip_q[NUSED] ? -y_q[NUSED] : y_q[NUSED];
endmodule
`default_nettype wire

// ----- hw/rtl/mobile_robot_kinematics_derivative.sv -----
`default_nettype none
// From accept to output valid: CORDIC registers, s1 to s4, output register.
// Throughput: one item per cycle while the output is not stalled; set by the
// CORDIC stage chain, one stage per register, three rotators in parallel.
// Stalls freeze the whole pipeline; an output register holds the last result.
// Reset (arst_n low, async) clears valid bits and loads register defaults.
module mobile_robot_kinematics_derivative
	import mrkd_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] heading,
	input  wire logic signed [15:0] left_caster_angle,
	input  wire logic signed [15:0] right_caster_angle,
	input  wire logic signed [15:0] linear_speed,
	input  wire logic signed [15:0] angular_speed,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      x_rate,
	output logic signed [31:0]      y_rate,
	output logic signed [15:0]      heading_rate,
	output logic signed [31:0]      left_caster_rate,
	output logic signed [31:0]      right_caster_rate
);
	localparam int NUSED = (CORDIC_STAGES < ATAN_TAB_SIZE) ? CORDIC_STAGES : ATAN_TAB_SIZE;
	localparam int CL = NUSED + 1;   // cordic latency
	localparam int DEPTH = CL + 4;   // total pipeline stages before output reg

	// config registers
	logic        caster_en_q;
	logic [15:0] track_q, base_q, inv_len_q;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			caster_en_q <= 1'b0;
			track_q     <= 16'd2048;
			base_q      <= 16'd2048;
			inv_len_q   <= 16'd4096;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_CASTER_EN: caster_en_q <= pwdata[0];
				REG_TRACK:     track_q <= pwdata[15:0];
				REG_BASE:      base_q <= pwdata[15:0];
				REG_INV_LEN:   inv_len_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		unique case (paddr[3:2])
			REG_CASTER_EN: prdata = {31'd0, caster_en_q};
			REG_TRACK:     prdata = {16'd0, track_q};
			REG_BASE:      prdata = {16'd0, base_q};
			REG_INV_LEN:   prdata = {16'd0, inv_len_q};
			default:       prdata = '0;
		endcase
	end

	// global stall: advance when output register free
	logic adv;
	logic [DEPTH-1:0] vld_q;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[DEPTH-2:0], in_valid};
	end

	// mount speeds, Q25, computed beside the CORDIC
	logic signed [15:0] v_d [CL];
	logic signed [15:0] w_d [CL];
	always_ff @(posedge clk) begin
		if (adv) begin
			v_d[0] <= linear_speed;
			w_d[0] <= angular_speed;
			for (int k = 1; k < CL; k++) begin
				v_d[k] <= v_d[k-1];
				w_d[k] <= w_d[k-1];
			end
		end
	end
	// products land in step with the last delay tap
	logic signed [33:0] wt_q, lat_q;
	always_ff @(posedge clk) begin
		if (adv) begin
			wt_q  <= 34'(w_d[CL-2]) * 34'($signed({1'b0, track_q}));
			lat_q <= -((34'(w_d[CL-2]) * 34'($signed({1'b0, base_q}))) <<< 1);
		end
	end
	logic signed [33:0] fl_c, fr_c;
	assign fl_c = 34'(v_d[CL-1] * 34'sd32768) - wt_q;
	assign fr_c = 34'(v_d[CL-1] * 34'sd32768) + wt_q;

	// three rotators
	logic signed [33:0] hs, hc, ls, lc, rs, rc;
	mrkd_cordic #(.STAGES(CORDIC_STAGES)) u_h (.clk, .en(adv),
		.ang(heading), .sin_q30(hs), .cos_q30(hc));
	mrkd_cordic #(.STAGES(CORDIC_STAGES)) u_l (.clk, .en(adv),
		.ang(left_caster_angle), .sin_q30(ls), .cos_q30(lc));
	mrkd_cordic #(.STAGES(CORDIC_STAGES)) u_r (.clk, .en(adv),
		.ang(right_caster_angle), .sin_q30(rs), .cos_q30(rc));

	// s1: products
	logic signed [63:0] xp_s1, yp_s1, llc_s1, lfs_s1, rlc_s1, rfs_s1;
	logic signed [15:0] w_s1, w_s2, w_s3, w_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			xp_s1  <= 64'(v_d[CL-1]) * 64'(hc);
			yp_s1  <= 64'(v_d[CL-1]) * 64'(hs);
			llc_s1 <= 64'(lat_q) * 64'(lc);
			lfs_s1 <= 64'(fl_c) * 64'(ls);
			rlc_s1 <= 64'(lat_q) * 64'(rc);
			rfs_s1 <= 64'(fr_c) * 64'(rs);
			w_s1   <= w_d[CL-1];
		end
	end

	// s2: differences, xy rounding
	logic signed [31:0] x_s2, y_s2, x_s3, y_s3, x_s4, y_s4;
	logic signed [44:0] ld_s2, rd_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2  <= sat32((xp_s1 + 64'sd524288) >>> 20);
			y_s2  <= sat32((yp_s1 + 64'sd524288) >>> 20);
			ld_s2 <= 45'((llc_s1 >>> 20) - (lfs_s1 >>> 20));
			rd_s2 <= 45'((rlc_s1 >>> 20) - (rfs_s1 >>> 20));
			w_s2  <= w_s1;
		end
	end

	// s3: scale by reciprocal length
	logic signed [63:0] lp_s3, rp_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			lp_s3 <= 64'(ld_s2) * 64'($signed({1'b0, inv_len_q}));
			rp_s3 <= 64'(rd_s2) * 64'($signed({1'b0, inv_len_q}));
			x_s3 <= x_s2; y_s3 <= y_s2; w_s3 <= w_s2;
		end
	end

	// s4: round and saturate; caster rates are zero while casters are disabled
	logic signed [31:0] l_s4, r_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			l_s4 <= caster_en_q ? sat32((lp_s3 + 64'sd67108864) >>> 27) : '0;
			r_s4 <= caster_en_q ? sat32((rp_s3 + 64'sd67108864) >>> 27) : '0;
			x_s4 <= x_s3; y_s4 <= y_s3; w_s4 <= w_s3;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= vld_q[DEPTH-1];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			x_rate <= x_s4;
			y_rate <= y_s4;
			heading_rate <= w_s4;
			left_caster_rate <= l_s4;
			right_caster_rate <= r_s4;
		end
	end
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
module tb;
	import mrkd_pkg::*;

	localparam int STAGES = CORDIC_STAGES_DEF;
	localparam int LATENCY = ((STAGES < ATAN_TAB_SIZE) ? STAGES : ATAN_TAB_SIZE) + 6;
	localparam int MAX_WAIT = 18;

	typedef struct packed {
		logic signed [15:0] heading;
		logic signed [15:0] left_ang;
		logic signed [15:0] right_ang;
		logic signed [15:0] lin_speed;
		logic signed [15:0] ang_speed;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] x_rate;
		logic signed [31:0] y_rate;
		logic signed [15:0] heading_rate;
		logic signed [31:0] left_rate;
		logic signed [31:0] right_rate;
	} deriv_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_ready;
	logic signed [15:0] heading, left_caster_angle, right_caster_angle;
	logic signed [15:0] linear_speed, angular_speed;
	logic out_valid, out_ready;
	logic signed [31:0] x_rate, y_rate, left_caster_rate, right_caster_rate;
	logic signed [15:0] heading_rate;

	mobile_robot_kinematics_derivative uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.heading(heading), .left_caster_angle(left_caster_angle),
		.right_caster_angle(right_caster_angle), .linear_speed(linear_speed),
		.angular_speed(angular_speed),
		.out_valid(out_valid), .out_ready(out_ready),
		.x_rate(x_rate), .y_rate(y_rate), .heading_rate(heading_rate),
		.left_caster_rate(left_caster_rate), .right_caster_rate(right_caster_rate)
	);

	// predictor copy of the registers
	logic        cfg_caster_en;
	logic [15:0] cfg_track;
	logic [15:0] cfg_base;
	logic [15:0] cfg_inv_len;

	cmd_t   pending_cmds[$];
	deriv_t expected_derivs[$];
	int     mismatches;
	int     sent_count;
	bit     hold_off;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// CORDIC rotation, Q30 results, folded beyond +-90 degrees
	function automatic void rotate_angle(input logic signed [15:0] ang,
		output longint s, output longint c);
		longint z, x, y, dx, dy, t;
		bit flip;
		z = longint'(ang) * 65536;
		x = 652032874;
		y = 0;
		flip = 0;
		if (z > 64'sh40000000) begin
			z = z - 64'sh80000000;
			flip = 1;
		end else if (z < -64'sh40000000) begin
			z = z + 64'sh80000000;
			flip = 1;
		end
		for (int i = 0; i < STAGES && i < ATAN_TAB_SIZE; i++) begin
			dx = fshift(y, i);
			dy = fshift(x, i);
			t = longint'(atan_entry(i));
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - t;
			end else begin
				x = x + dx; y = y - dy; z = z + t;
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint swivel_rate(longint fwd, longint lat,
		logic signed [15:0] ang);
		longint s, c, d;
		rotate_angle(ang, s, c);
		d = fshift(lat * c, 20) - fshift(fwd * s, 20);
		return clamp32(fshift(d * longint'(cfg_inv_len) + (64'sd1 <<< 26), 27));
	endfunction

	function automatic deriv_t predict_deriv(cmd_t cmd);
		deriv_t r;
		longint s, c, v, w, v25, wt, lat;
		v = cmd.lin_speed;
		w = cmd.ang_speed;
		rotate_angle(cmd.heading, s, c);
		r.x_rate = 32'(clamp32(fshift(v * c + (64'sd1 <<< 19), 20)));
		r.y_rate = 32'(clamp32(fshift(v * s + (64'sd1 <<< 19), 20)));
		r.heading_rate = cmd.ang_speed;
		r.left_rate = 0;
		r.right_rate = 0;
		if (cfg_caster_en) begin
			v25 = v * 32768;
			wt = w * longint'(cfg_track);
			lat = -2 * w * longint'(cfg_base);
			r.left_rate = 32'(swivel_rate(v25 - wt, lat, cmd.left_ang));
			r.right_rate = 32'(swivel_rate(v25 + wt, lat, cmd.right_ang));
		end
		return r;
	endfunction

	// APB write, setup then access
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_CASTER_EN: cfg_caster_en = val[0];
			REG_TRACK:     cfg_track = val[15:0];
			REG_BASE:      cfg_base = val[15:0];
			default:       cfg_inv_len = val[15:0];
		endcase
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic push_cmd(logic [15:0] h, logic [15:0] al, logic [15:0] ar,
		logic [15:0] v, logic [15:0] w);
		cmd_t c;
		c.heading = h; c.left_ang = al; c.right_ang = ar;
		c.lin_speed = v; c.ang_speed = w;
		pending_cmds = {pending_cmds, c};
	endtask

	task automatic push_random(int n);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 3))
				0: push_cmd(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom));
				1: push_cmd(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom_range(0, 2047) - 1024),
					16'($urandom_range(0, 8191) - 4096));
				2: push_cmd(16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 2) - 1),
					16'($urandom_range(0, 3) * 16384),
					16'($urandom_range(0, 1) * 32768 - 1),
					$urandom_range(0, 1) ? 16'h7FFF : 16'h8000, 16'($urandom));
				default: push_cmd(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom_range(0, 255)),
					$urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
			endcase
		end
	endtask

	// let the pipeline drain before touching registers
	task automatic drain();
		while (pending_cmds.size() != 0 || in_valid || expected_derivs.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// high when the item on the input was taken at the last rising edge
	logic in_ready_q;

	// driver: offer one item per draw of idle cycles
	int send_gap;
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ready_q) begin
				if (in_valid)
					send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, MAX_WAIT);
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_cmds.size() != 0) begin
					cmd_t c;
					c = pending_cmds.pop_front();
					heading <= c.heading; left_caster_angle <= c.left_ang;
					right_caster_angle <= c.right_ang; linear_speed <= c.lin_speed;
					angular_speed <= c.ang_speed;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// accept tracking at the rising edge, prediction at acceptance
	always @(posedge clk) begin
		in_ready_q <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			cmd_t c;
			c.heading = heading; c.left_ang = left_caster_angle;
			c.right_ang = right_caster_angle; c.lin_speed = linear_speed;
			c.ang_speed = angular_speed;
			expected_derivs = {expected_derivs, predict_deriv(c)};
			sent_count++;
		end
	end

	// receiver stalls
	int recv_gap;
	always @(negedge clk) begin
		if (!arst_n || hold_off) begin
			out_ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (out_valid && out_ready)
				recv_gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, MAX_WAIT);
		end
	end

	// monitor: compare with oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			deriv_t got, want;
			got.x_rate = x_rate; got.y_rate = y_rate; got.heading_rate = heading_rate;
			got.left_rate = left_caster_rate; got.right_rate = right_caster_rate;
			if (expected_derivs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected item %p", got);
			end else begin
				want = expected_derivs.pop_front();
				if (got.x_rate !== want.x_rate || got.y_rate !== want.y_rate ||
					got.heading_rate !== want.heading_rate ||
					got.left_rate !== want.left_rate ||
					got.right_rate !== want.right_rate) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p got %p", want, got);
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("mobile_robot_kinematics_derivative test failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_valid = 1'b0; out_ready = 1'b0; hold_off = 1'b0;
		heading = '0; left_caster_angle = '0; right_caster_angle = '0;
		linear_speed = '0; angular_speed = '0;
		send_gap = 0; recv_gap = 0; mismatches = 0; sent_count = 0;
		cfg_caster_en = 1'b0; cfg_track = 16'd2048; cfg_base = 16'd2048;
		cfg_inv_len = 16'd4096;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: casters off
		push_cmd(16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF);
		push_cmd(16'h4000, 16'hC000, 16'h8000, 16'h8000, 16'h8000);
		push_cmd(16'h8000, 16'h7FFF, 16'h4001, 16'h7FFF, 16'h0001);
		push_cmd(16'hBFFF, 16'h3FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_random(8);
		drain();

		// casters on, extreme geometry for saturation
		write_reg(REG_CASTER_EN, 32'hFFFF_FFFF);
		write_reg(REG_TRACK, 32'hFFFF_FFFF);
		write_reg(REG_BASE, 32'h0001_FFFF);
		write_reg(REG_INV_LEN, 32'h0000_FFFF);
		push_cmd(16'h0000, 16'h4000, 16'hC000, 16'h7FFF, 16'h7FFF);
		push_cmd(16'h1234, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000);
		push_cmd(16'hFFFF, 16'h0001, 16'h0000, 16'h0000, 16'h7FFF);
		push_cmd(16'h5555, 16'hAAAA, 16'h5555, 16'h7FFF, 16'h8000);
		push_random(6);
		drain();

		// zero geometry
		write_reg(REG_TRACK, 32'd0);
		write_reg(REG_BASE, 32'd0);
		write_reg(REG_INV_LEN, 32'd0);
		push_random(40);
		drain();

		// nominal geometry, long receiver hold-off while the sender keeps going
		write_reg(REG_TRACK, 32'd2200);
		write_reg(REG_BASE, 32'd1500);
		write_reg(REG_INV_LEN, 32'd8192);
		hold_off = 1'b1;
		push_random(80);
		repeat (200) @(posedge clk);
		hold_off = 1'b0;
		drain();

		// random settings
		for (int p = 0; p < 6; p++) begin
			write_reg(REG_CASTER_EN, $urandom);
			write_reg(REG_TRACK, $urandom);
			write_reg(REG_BASE, $urandom_range(0, 4095));
			write_reg(REG_INV_LEN, $urandom);
			push_random(65);
			drain();
		end

		if (mismatches == 0) begin
			$display("mobile_robot_kinematics_derivative test passed");
		end else begin
			$display("mobile_robot_kinematics_derivative test failed");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
hw/rtl/mrkd_pkg.sv
hw/rtl/mrkd_cordic.sv
hw/rtl/mobile_robot_kinematics_derivative.sv
sim/tb.sv
